// ===== rtl/core/tgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tgrs_pkg
// Shared types and constants for the timed grip-and-release sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tgrs_pkg;

  // Timer width default and the fixed widths of the ports.
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_ADDR_W      = 2;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 8;
  localparam int IN_FIELDS_W     = 5;
  localparam int PHASE_W         = 4;

  // Reset values of the configuration registers, in ticks.
  localparam logic [CFG_DATA_W-1:0] FINGER_TO_RELEASE_RST = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RETRACT_WAIT_RST      = 16'd100;
  localparam logic [CFG_DATA_W-1:0] POST_RELEASE_RST      = 16'd200;

  // Actuator drive levels.
  localparam logic GRIP_CLOSED    = 1'b1;
  localparam logic GRIP_OPEN      = 1'b0;
  localparam logic FINGER_ACTIVE  = 1'b1;
  localparam logic FINGER_RELAXED = 1'b0;

  // Command codes carried in the cmd field.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FINGER_TO_RELEASE = 2'd0,
    CFG_RETRACT_WAIT      = 2'd1,
    CFG_POST_RELEASE      = 2'd2
  } cfg_idx_t;

  // Sequencer phases.
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 4'd0,
    PH_BEGIN   = 4'd1,
    PH_READY   = 4'd2,
    PH_HOLD    = 4'd3,
    PH_RETRACT = 4'd4,
    PH_SETTLE  = 4'd5,
    PH_AWAIT   = 4'd6,
    PH_POST    = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  // One input word, cmd in the lowest bit.
  typedef struct packed {
    logic ball_seen;
    logic limit_inner;
    logic limit_outer;
    logic arm_reached;
    logic cmd;
  } in_item_t;

  // One result word, the finger drive level in the lowest bit.
  typedef struct packed {
    logic               done_res;
    logic [PHASE_W-1:0] phase;
    logic               arm_out;
    logic               grip_drv;
    logic               finger_drv;
  } out_item_t;

endpackage : tgrs_pkg

`default_nettype wire

// ===== rtl/core/timed_grip_release_sequencer.sv =====
// ----------------------------------------------------------------------------
// timed_grip_release_sequencer
// Path: an accepted input word is held in the input register, then its result
// word in the result register (one input register, one result register).
// Throughput: one word per cycle, sustained, as long as results are taken.
// Reset (rst_n low, synchronous): idle phase, timer cleared, all drives off,
// registers back to 100/100/200 ticks, both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_grip_release_sequencer #(
  parameter int TIMER_WIDTH = tgrs_pkg::TIMER_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Configuration write port
  input  wire                                  cfg_we,
  input  wire  [tgrs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire  [tgrs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // Input stream
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: cmd, arm_reached, limit_outer, limit_inner, ball_seen,
  // then three bits that are ignored.
  input  wire  [tgrs_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Result stream
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // Fields from bit 0: finger drive, grip drive, arm_out, phase[3:0], done_res.
  output logic [tgrs_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  import tgrs_pkg::*;

  // The comparison runs at the wider of the timer and the register width, so
  // that a narrow timer still compares correctly against a 16-bit limit.
  localparam int CMP_W = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  // --------------------------------------------------------------------------
  // Config registers: the user writes only while the block is idle; not enforced.
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] finger_to_release_r;
  logic [CFG_DATA_W-1:0] retract_wait_r;
  logic [CFG_DATA_W-1:0] post_release_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finger_to_release_r <= FINGER_TO_RELEASE_RST;
      retract_wait_r      <= RETRACT_WAIT_RST;
      post_release_r      <= POST_RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FINGER_TO_RELEASE: finger_to_release_r <= cfg_wdata;
        CFG_RETRACT_WAIT:      retract_wait_r      <= cfg_wdata;
        CFG_POST_RELEASE:      post_release_r      <= cfg_wdata;
        default: ;  // Indexes beyond the list are ignored.
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. A word sits here for the cycle in which the sequencer
  // state is updated from it; it moves on whenever the result register can
  // take the outcome, so a new word may enter in the same cycle.
  // --------------------------------------------------------------------------
  logic     in_valid_r;
  in_item_t in_item_r;
  logic     advance;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_tdata[IN_FIELDS_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state.
  // --------------------------------------------------------------------------
  phase_t                 phase_r,   phase_nxt;
  logic [TIMER_WIDTH-1:0] wait_cnt_r, wait_cnt_nxt;
  logic                   finger_r,  finger_nxt;
  logic                   gripper_r, gripper_nxt;
  logic                   arm_out_r, arm_out_nxt;

  // Timer step shared by the three timed phases: the count plus one,
  // saturating, checked against the limit of the current phase.
  logic [CFG_DATA_W-1:0]  wait_limit;
  logic [TIMER_WIDTH-1:0] wait_inc;
  logic                   wait_done;
  logic                   arm_stop;

  always_comb begin
    case (phase_r)
      PH_HOLD:    wait_limit = finger_to_release_r;
      PH_RETRACT: wait_limit = retract_wait_r;
      default:    wait_limit = post_release_r;
    endcase
  end

  assign wait_inc  = (wait_cnt_r == TIMER_MAX) ? wait_cnt_r
                                               : wait_cnt_r + 1'b1;
  assign wait_done = CMP_W'(wait_inc) >= CMP_W'(wait_limit);
  assign arm_stop  = in_item_r.arm_reached || in_item_r.limit_outer ||
                     in_item_r.limit_inner;

  // Next phase. A start request restarts the sequence from any phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_item_r.cmd == CMD_START) begin
      phase_nxt = PH_BEGIN;
    end else begin
      unique case (phase_r)
        PH_BEGIN:   phase_nxt = PH_READY;
        PH_READY:   if (arm_stop)              phase_nxt = PH_HOLD;
        PH_HOLD:    if (wait_done)             phase_nxt = PH_RETRACT;
        PH_RETRACT: if (wait_done)             phase_nxt = PH_SETTLE;
        PH_SETTLE:  if (wait_done)             phase_nxt = PH_AWAIT;
        PH_AWAIT:   if (in_item_r.ball_seen)   phase_nxt = PH_POST;
        PH_POST:    if (in_item_r.arm_reached) phase_nxt = PH_DONE;
        default:    phase_nxt = phase_r;  // Idle, complete and unused codes.
      endcase
    end
  end

  // Drive levels and timer. A start clears the timer but keeps the drives.
  always_comb begin
    finger_nxt   = finger_r;
    gripper_nxt  = gripper_r;
    arm_out_nxt  = arm_out_r;
    wait_cnt_nxt = wait_cnt_r;
    if (in_item_r.cmd == CMD_START) begin
      wait_cnt_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_READY: begin
          gripper_nxt = GRIP_CLOSED;
          arm_out_nxt = 1'b1;
          if (arm_stop) begin
            finger_nxt   = FINGER_ACTIVE;
            wait_cnt_nxt = '0;
          end
        end
        PH_HOLD: begin
          wait_cnt_nxt = wait_done ? '0 : wait_inc;
          if (wait_done) gripper_nxt = GRIP_OPEN;
        end
        PH_RETRACT: begin
          wait_cnt_nxt = wait_done ? '0 : wait_inc;
          if (wait_done) finger_nxt = FINGER_RELAXED;
        end
        PH_SETTLE: begin
          wait_cnt_nxt = wait_done ? '0 : wait_inc;
        end
        PH_AWAIT: begin
          if (in_item_r.ball_seen) gripper_nxt = GRIP_CLOSED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      wait_cnt_r <= '0;
      finger_r   <= FINGER_RELAXED;
      gripper_r  <= GRIP_OPEN;
      arm_out_r  <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      finger_r   <= finger_nxt;
      gripper_r  <= gripper_nxt;
      arm_out_r  <= arm_out_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. It holds the state after the update until it is taken;
  // the input register keeps accepting while it is empty or being emptied.
  // --------------------------------------------------------------------------
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.finger_drv <= finger_nxt;
      out_item_r.grip_drv   <= gripper_nxt;
      out_item_r.arm_out    <= arm_out_nxt;
      out_item_r.phase      <= phase_nxt;
      out_item_r.done_res   <= (phase_nxt == PH_DONE);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

`ifndef SYNTHESIS
  // The timer only ever holds a count inside the three timed phases.
  a_timer_idle_outside_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_cnt_r != '0) |-> (phase_r == PH_HOLD || phase_r == PH_RETRACT ||
                            phase_r == PH_SETTLE))
    else $error("timer holds a count outside a timed phase");

  // A processed start request always lands in the begin phase.
  a_start_to_begin: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.cmd == CMD_START) |=> (phase_r == PH_BEGIN))
    else $error("start request did not restart the sequence");

  // Leaving ready on a stop condition turns the finger on and enters hold.
  a_ready_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.cmd == CMD_TICK && phase_r == PH_READY && arm_stop)
      |=> (phase_r == PH_HOLD && finger_r == FINGER_ACTIVE && wait_cnt_r == '0))
    else $error("ready phase did not hand over to hold correctly");

  // With the result register empty, the input side never stalls.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

  // A result word always reports the phase and completion flag consistently.
  a_done_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.done_res == (out_item_r.phase == PH_DONE)))
    else $error("completion flag disagrees with reported phase");
`endif

endmodule : timed_grip_release_sequencer

`default_nettype wire

// ===== sim/grip_seq_checker.sv =====
// ----------------------------------------------------------------------------
// grip_seq_checker
// Watches the configuration port and both streams of the grip-and-release
// sequencer, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grip_seq_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tgrs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tgrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // Fields from bit 0: cmd, arm_reached, limit_outer, limit_inner, ball_seen.
  input  logic [tgrs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: finger drive, grip drive, arm_out, phase[3:0], done_res.
  input  logic [tgrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               fail_count,
  output int                               pending,
  output int                               checked,
  output logic [8:0]                       phases_seen
);

  import tgrs_pkg::*;

  localparam int TW = TIMER_WIDTH_DEF;

  phase_t                seq_phase;
  logic [TW-1:0]         wait_ticks;
  logic                  finger_lvl;
  logic                  gripper_lvl;
  logic                  arm_lvl;
  logic [CFG_DATA_W-1:0] hold_ticks;
  logic [CFG_DATA_W-1:0] retract_ticks;
  logic [CFG_DATA_W-1:0] settle_ticks;
  out_item_t             expected_q[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    checked     = 0;
    phases_seen = '0;
  end

  // One tick of a timed wait; the counter saturates at its maximum.
  function automatic bit wait_over(input logic [CFG_DATA_W-1:0] limit);
    logic [TW-1:0] nxt;
    nxt = (wait_ticks == {TW{1'b1}}) ? wait_ticks : wait_ticks + 1'b1;
    if (nxt >= limit) begin
      wait_ticks = '0;
      return 1'b1;
    end
    wait_ticks = nxt;
    return 1'b0;
  endfunction

  task automatic advance(input in_item_t w);
    out_item_t r;
    if (w.cmd == CMD_START) begin
      seq_phase  = PH_BEGIN;
      wait_ticks = '0;
    end else begin
      case (seq_phase)
        PH_BEGIN: seq_phase = PH_READY;
        PH_READY: begin
          gripper_lvl = GRIP_CLOSED;
          arm_lvl     = 1'b1;
          if (w.arm_reached || w.limit_outer || w.limit_inner) begin
            finger_lvl = FINGER_ACTIVE;
            wait_ticks = '0;
            seq_phase  = PH_HOLD;
          end
        end
        PH_HOLD: if (wait_over(hold_ticks)) begin
          gripper_lvl = GRIP_OPEN;
          seq_phase   = PH_RETRACT;
        end
        PH_RETRACT: if (wait_over(retract_ticks)) begin
          finger_lvl = FINGER_RELAXED;
          seq_phase  = PH_SETTLE;
        end
        PH_SETTLE: if (wait_over(settle_ticks)) seq_phase = PH_AWAIT;
        PH_AWAIT: if (w.ball_seen) begin
          gripper_lvl = GRIP_CLOSED;
          seq_phase   = PH_POST;
        end
        PH_POST: if (w.arm_reached) seq_phase = PH_DONE;
        default: ;
      endcase
    end
    r.finger_drv = finger_lvl;
    r.grip_drv   = gripper_lvl;
    r.arm_out    = arm_lvl;
    r.phase      = seq_phase;
    r.done_res   = (seq_phase == PH_DONE);
    expected_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase     = PH_IDLE;
      wait_ticks    = '0;
      finger_lvl    = FINGER_RELAXED;
      gripper_lvl   = GRIP_OPEN;
      arm_lvl       = 1'b0;
      hold_ticks    = FINGER_TO_RELEASE_RST;
      retract_ticks = RETRACT_WAIT_RST;
      settle_ticks  = POST_RELEASE_RST;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_FINGER_TO_RELEASE: hold_ticks    = cfg_wdata;
          CFG_RETRACT_WAIT:      retract_ticks = cfg_wdata;
          CFG_POST_RELEASE:      settle_ticks  = cfg_wdata;
          default: ;
        endcase
      end
      // Results are compared before the new word is predicted, so a word can
      // never be matched against its own expectation in the same cycle.
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word 0x%0h arrived with nothing expected", out_tdata);
          fail_count++;
        end else begin
          out_item_t want;
          out_item_t got;
          want = expected_q.pop_front();
          got  = out_item_t'(out_tdata);
          check_field("finger_drv", want.finger_drv, got.finger_drv);
          check_field("grip_drv", want.grip_drv, got.grip_drv);
          check_field("arm_out", want.arm_out, got.arm_out);
          check_field("phase", want.phase, got.phase);
          check_field("done_res", want.done_res, got.done_res);
          checked++;
          if (got.phase <= PH_DONE) phases_seen[got.phase] = 1'b1;
        end
      end
      if (in_tvalid && in_tready) advance(in_item_t'(in_tdata[IN_FIELDS_W-1:0]));
    end
    pending = expected_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the timed grip-and-release sequencer: directed
// walks through every phase, one long timed wait, then random grip
// sequences under several idling mixes and one long back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tgrs_pkg::*;

  // Generous bound on the whole run, even under the heaviest idling mixes and
  // the long hold-off.
  localparam int CYCLE_LIMIT = 100_000;
  // Length of the receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;

  typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idling_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = CFG_FINGER_TO_RELEASE;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // Fields from bit 0: cmd, arm_reached, limit_outer, limit_inner, ball_seen.
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // Fields from bit 0: finger drive, grip drive, arm_out, phase[3:0], done_res.
  logic [OUT_TDATA_W-1:0] out_tdata;

  int          fail_count;
  int          pending;
  int          checked;
  logic [8:0]  phases_seen;
  int          words_sent   = 0;
  int          cycle_count  = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  logic        fill_go      = 1'b0;
  logic        rx_hold      = 1'b0;

  timed_grip_release_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  grip_seq_checker seq_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .phases_seen (phases_seen)
  );

  // Two-nanosecond clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver takes results at random according to the current stall rate,
  // and never while the long hold-off is in force.
  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Long hold-off on the result side. Once the fill phase starts, the receiver
  // refuses results for the length of the hold-off while the sender keeps on
  // offering words, so both pipeline registers fill and in_tready falls.
  initial begin : long_hold
    wait (fill_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic in_item_t word_of(input logic c, arm, lo, li, ball);
    in_item_t w;
    w.cmd         = c;
    w.arm_reached = arm;
    w.limit_outer = lo;
    w.limit_inner = li;
    w.ball_seen   = ball;
    return w;
  endfunction

  // A tick with sparse sensor activity, so that sequences linger in each
  // phase for a while; now and then a wholly random word, which may restart.
  function automatic in_item_t noisy_tick();
    in_item_t w;
    if ($urandom_range(99) < 8) begin
      w = in_item_t'(IN_FIELDS_W'($urandom));
    end else begin
      w = word_of(CMD_TICK, $urandom_range(99) < 12, $urandom_range(99) < 5,
                  $urandom_range(99) < 5, $urandom_range(99) < 15);
    end
    return w;
  endfunction

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_TX:   begin tx_idle_pct = 55; rx_stall_pct = 0;  end
      IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 55; end
      default:   begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
    endcase
  endtask

  // Offers one word and returns at the edge where it is taken. tvalid stays
  // high into the next word unless the sender decides to idle first. The
  // ready flag is looked at on the falling edge, where it has settled for the
  // coming rising edge.
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(w);
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // Stops sending and waits until every predicted result has been taken,
  // then lets the two pipeline stages run dry.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three timer registers back to back; only called while idle.
  task automatic load_timers(input logic [CFG_DATA_W-1:0] hold_t, retract_t,
                             settle_t);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FINGER_TO_RELEASE;
    cfg_wdata <= hold_t;
    @(posedge clk);
    cfg_addr  <= CFG_RETRACT_WAIT;
    cfg_wdata <= retract_t;
    @(posedge clk);
    cfg_addr  <= CFG_POST_RELEASE;
    cfg_wdata <= settle_t;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Well-formed grip sequences with random content: a start word, then a run
  // of noisy ticks long enough for small timer settings to reach completion.
  task automatic run_sequences(input int n_words);
    int       left;
    int       len;
    in_item_t w;
    left = n_words;
    while (left > 0) begin
      w     = in_item_t'(IN_FIELDS_W'($urandom));
      w.cmd = CMD_START;
      send_word(w);
      left--;
      len = $urandom_range(10, 120);
      while (len > 0 && left > 0) begin
        send_word(noisy_tick());
        len--;
        left--;
      end
    end
  endtask

  initial begin : stimulus
    int                    seg;
    logic [CFG_DATA_W-1:0] t_hold;
    logic [CFG_DATA_W-1:0] t_retract;
    logic [CFG_DATA_W-1:0] t_settle;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk with short timers: zero, one and two ticks.
    load_timers(16'd0, 16'd1, 16'd2);
    set_idling(IDLE_NONE);
    // Ticks in idle change nothing, whatever the sensors say.
    send_word(word_of(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    // Start with every sensor active; begin ignores the sensors too.
    send_word(word_of(CMD_START, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1));
    // Ready: the ball sensor alone does nothing, the inner limit triggers.
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b0));
    // Hold with a zero register and retract with a one both act at once.
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    // Settle ignores the sensors and needs two ticks.
    send_word(word_of(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    // Await ball ignores arm reached; the ball sensor closes the gripper.
    send_word(word_of(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
    // Post ignores everything but arm reached.
    send_word(word_of(CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CMD_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
    // Complete holds still on ticks; a start restarts with drives kept.
    send_word(word_of(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CMD_START, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    // Outer limit triggers the hold; a start in the middle of a wait restarts.
    send_word(word_of(CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(word_of(CMD_START, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b1, 1'b0, 1'b0, 1'b0));

    // One long hold: a register of 200 acts on its 200th tick and not one
    // earlier.
    drain();
    load_timers(16'd200, 16'd0, 16'd1);
    send_word(word_of(CMD_START, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (200) send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CMD_TICK, 1'b1, 1'b0, 1'b0, 1'b0));

    // Random segments, each with its own timer setting and idling mix; every
    // mix comes round twice. Segment two uses the largest values everywhere,
    // where no sequence ever gets past the hold.
    for (seg = 0; seg < 8; seg++) begin
      drain();
      case (seg)
        0: begin t_hold = 16'd0; t_retract = 16'd0; t_settle = 16'd0; end
        1: begin t_hold = 16'd1; t_retract = 16'd1; t_settle = 16'd1; end
        2: begin t_hold = 16'hFFFF; t_retract = 16'hFFFF; t_settle = 16'hFFFF; end
        5: begin
          t_hold    = CFG_DATA_W'($urandom_range(7, 40));
          t_retract = CFG_DATA_W'($urandom_range(7, 40));
          t_settle  = CFG_DATA_W'($urandom_range(7, 40));
        end
        default: begin
          t_hold    = CFG_DATA_W'($urandom_range(0, 6));
          t_retract = CFG_DATA_W'($urandom_range(0, 6));
          t_settle  = CFG_DATA_W'($urandom_range(0, 6));
        end
      endcase
      load_timers(t_hold, t_retract, t_settle);
      set_idling(idling_t'(seg % 4));
      run_sequences(100);
    end

    // Fill phase: the sender offers words flat out while the receiver holds
    // off for a long stretch.
    drain();
    load_timers(CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 6)),
                CFG_DATA_W'($urandom_range(0, 6)));
    set_idling(IDLE_NONE);
    fill_go <= 1'b1;
    run_sequences(60);
    drain();

    $display("Run covered %0d input words and %0d checked result words,",
             words_sent, checked);
    $display("with phase codes seen (bit per code, complete at the top): %b",
             phases_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
